// ===== hw/rtl/bts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

    // default parameter values
    localparam int DEF_TEXEL_STORE_DEPTH = 65536;
    localparam int DEF_COORD_FRAC_BITS   = 16;
    localparam int DEF_WEIGHT_FRAC_BITS  = 8;

    // fixed field widths
    localparam int SIZE_W    = 9;
    localparam int VAL_W     = 18;
    localparam int CH_W      = 8;
    localparam int OUT_W     = 16;
    localparam int IDX_W     = 16;
    localparam int COORD_W   = 32;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'd1;

    // item functions
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

endpackage

// ===== hw/rtl/bts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bts_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_axis
// Two-stage axis setup: scales the coordinate fraction by the texture size,
// then derives the two wrapped neighbour indexes and the blend weight.
// ----------------------------------------------------------------------------
module bts_axis
    import bts_pkg::*;
#(
    parameter int COORD_FRAC_BITS  = DEF_COORD_FRAC_BITS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic [COORD_FRAC_BITS:0]    i_frac,
    input  logic [SIZE_W-1:0]           i_size,
    output logic [SIZE_W-1:0]           o_i0,
    output logic [SIZE_W-1:0]           o_i1,
    output logic [WEIGHT_FRAC_BITS-1:0] o_wt
);

    localparam int C  = COORD_FRAC_BITS;
    localparam int W  = WEIGHT_FRAC_BITS;
    localparam int SW = C + SIZE_W + 1;
    localparam int SR = (C >= W) ? C - W : 0;
    localparam int SL = (C >= W) ? 0 : W - C;
    localparam logic [SW-1:0] HALF = SW'(1) << (C - 1);

    logic [SW-1:0]     r_s;
    logic [SIZE_W-1:0] r_n;
    logic [SIZE_W:0]   fl;
    logic [SIZE_W-1:0] n_i0;
    logic [SIZE_W-1:0] n_i1;
    logic [C+W-1:0]    wtmp;
    logic [SIZE_W-1:0] r_i0;
    logic [SIZE_W-1:0] r_i1;
    logic [W-1:0]      r_wt;

    // scaled position plus half a texel
    always_ff @(posedge i_clk) begin
        r_s <= SW'(i_frac) * SW'(i_size) + HALF;
        r_n <= i_size;
    end

    // base minus one and next neighbour, both wrapped
    always_comb begin
        fl   = r_s[SW-1:C];
        n_i0 = (fl == '0) ? r_n - SIZE_W'(1) : SIZE_W'(fl - (SIZE_W+1)'(1));
        n_i1 = (n_i0 == r_n - SIZE_W'(1)) ? '0 : n_i0 + SIZE_W'(1);
        wtmp = ((C+W)'(r_s[C-1:0]) >> SR) << SL;
    end

    always_ff @(posedge i_clk) begin
        r_i0 <= n_i0;
        r_i1 <= n_i1;
        r_wt <= wtmp[W-1:0];
    end

    assign o_i0 = r_i0;
    assign o_i1 = r_i1;
    assign o_wt = r_wt;

endmodule

// ===== hw/rtl/bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Texel store with bilinear, repeat-wrapped sampling in a fixed pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with i_start high and o_busy low. With
//   i_func at write it stores one RGB texel at i_texel_index and gives no
//   result; with i_func at sample it filters at i_u_coord / i_v_coord.
//   A sample result appears on o_out_* with o_valid high for one cycle,
//   from the result registers after the last stage, and is taken while
//   o_valid is high; it must be taken then.
//   Throughput is one item per cycle while o_busy is low: every stage is
//   registered and the four neighbour fetches go to four copies of the
//   texel store, all written together, each with one read port.
//   Writes reach the store at the same pipeline stage as sample reads, so
//   items see the store in the order they were given.
//   Store addresses are reduced modulo the store depth by a reciprocal
//   multiply and a multiply-subtract over two stages.
//   Texture width and height are written through i_cfg_* while no item is
//   in flight; a size of zero is used as one.
//   Reset (i_rst_n low, synchronous) empties the pipeline and sets both
//   sizes to one; o_busy is high during reset and in the cycle after it.
//   The store is not cleared: a texel must be written before it is sampled.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler
    import bts_pkg::*;
#(
    parameter int TEXEL_STORE_DEPTH = DEF_TEXEL_STORE_DEPTH,
    parameter int COORD_FRAC_BITS   = DEF_COORD_FRAC_BITS,
    parameter int WEIGHT_FRAC_BITS  = DEF_WEIGHT_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_func,
    input  logic [IDX_W-1:0]         i_texel_index,
    input  logic [CH_W-1:0]          i_in_red,
    input  logic [CH_W-1:0]          i_in_green,
    input  logic [CH_W-1:0]          i_in_blue,
    input  logic signed [COORD_W-1:0] i_u_coord,
    input  logic signed [COORD_W-1:0] i_v_coord,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [SIZE_W-1:0]        i_cfg_data,
    output logic                     o_valid,
    output logic [OUT_W-1:0]         o_out_red,
    output logic [OUT_W-1:0]         o_out_green,
    output logic [OUT_W-1:0]         o_out_blue
);

    localparam int C   = COORD_FRAC_BITS;
    localparam int W   = WEIGHT_FRAC_BITS;
    localparam int D   = TEXEL_STORE_DEPTH;
    localparam int AW  = (D > 1) ? $clog2(D) : 1;
    localparam int LW  = $clog2(D);
    localparam int DW  = $clog2(D + 1);
    localparam int MW  = VAL_W + 1;
    localparam int PW  = VAL_W + MW;
    localparam int QW  = VAL_W + DW;
    localparam int TW  = W + CH_W + 1;
    localparam int VW  = 2 * W + CH_W + 2;
    localparam int RW  = 3 * CH_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << (VAL_W + LW)) + 64'(D) - 64'd1) / 64'(D);
    localparam logic [C:0] ONE  = (C+1)'(1) << C;
    localparam logic [W:0] WONE = (W+1)'(1) << W;

    logic              r_busy;
    logic [SIZE_W-1:0] r_tex_w;
    logic [SIZE_W-1:0] r_tex_h;
    logic [SIZE_W-1:0] size_w;
    logic [SIZE_W-1:0] size_h;
    logic              in_acc;
    logic [C:0]        frac_u;
    logic [C:0]        frac_v;

    logic              r_vld [1:8];
    logic              r_smp [1:8];
    logic [IDX_W-1:0]  r_widx [1:6];
    logic [RW-1:0]     r_wrgb [1:6];

    logic [SIZE_W-1:0] x0, x1, y0, y1;
    logic [W-1:0]      wx, wy;
    logic [W-1:0]      r_wx [3:7];
    logic [W-1:0]      r_wy [3:8];

    logic [VAL_W-1:0]  r_p0, r_p1;
    logic [SIZE_W-1:0] r_x0, r_x1;
    logic [VAL_W-1:0]  r_val4 [4];
    logic [PW-1:0]     r_prod5 [4];
    logic [VAL_W-1:0]  r_val5 [4];
    logic [QW-1:0]     r_qd6 [4];
    logic [VAL_W-1:0]  r_val6 [4];
    logic [PW-1:0]     qshift [4];
    logic [QW-1:0]     diff [4];
    logic [RW-1:0]     rdata [4];

    logic              ram_we;
    logic [TW-1:0]     r_top [3];
    logic [TW-1:0]     r_bot [3];
    logic [VW+7:0]     blend [3];
    logic [OUT_W-1:0]  r_out [3];
    logic              r_ovld;

    // busy while reset is held and in the cycle after
    always_ff @(posedge i_clk) begin
        r_busy <= !i_rst_n;
    end
    assign o_busy = r_busy || !i_rst_n;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= SIZE_W'(1);
            r_tex_h <= SIZE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEX_WIDTH:  r_tex_w <= i_cfg_data;
                CFG_TEX_HEIGHT: r_tex_h <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign size_w = (r_tex_w == '0) ? SIZE_W'(1) : r_tex_w;
    assign size_h = (r_tex_h == '0) ? SIZE_W'(1) : r_tex_h;

    // coordinate fractions, v flipped
    assign in_acc = i_start && !o_busy;
    assign frac_u = {1'b0, i_u_coord[C-1:0]};
    assign frac_v = ONE - {1'b0, i_v_coord[C-1:0]};

    // item valid line and write payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 8; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[1] <= in_acc;
            for (int k = 2; k <= 8; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp[1]  <= (i_func == FUNC_SAMPLE);
        r_widx[1] <= i_texel_index;
        r_wrgb[1] <= {i_in_red, i_in_green, i_in_blue};
        for (int k = 2; k <= 8; k++) begin
            r_smp[k] <= r_smp[k-1];
        end
        for (int k = 2; k <= 6; k++) begin
            r_widx[k] <= r_widx[k-1];
            r_wrgb[k] <= r_wrgb[k-1];
        end
    end

    // axis setup, stages one and two
    bts_axis #(
        .COORD_FRAC_BITS  (C),
        .WEIGHT_FRAC_BITS (W)
    ) u_axis_x (
        .i_clk  (i_clk),
        .i_frac (frac_u),
        .i_size (size_w),
        .o_i0   (x0),
        .o_i1   (x1),
        .o_wt   (wx)
    );

    bts_axis #(
        .COORD_FRAC_BITS  (C),
        .WEIGHT_FRAC_BITS (W)
    ) u_axis_y (
        .i_clk  (i_clk),
        .i_frac (frac_v),
        .i_size (size_h),
        .o_i0   (y0),
        .o_i1   (y1),
        .o_wt   (wy)
    );

    // weight carry lines
    always_ff @(posedge i_clk) begin
        r_wx[3] <= wx;
        r_wy[3] <= wy;
        for (int k = 4; k <= 7; k++) begin
            r_wx[k] <= r_wx[k-1];
        end
        for (int k = 4; k <= 8; k++) begin
            r_wy[k] <= r_wy[k-1];
        end
    end

    // row offsets, stage three
    always_ff @(posedge i_clk) begin
        r_p0 <= VAL_W'(y0) * VAL_W'(size_w);
        r_p1 <= VAL_W'(y1) * VAL_W'(size_w);
        r_x0 <= x0;
        r_x1 <= x1;
    end

    // linear indexes of the four neighbours, stage four
    always_ff @(posedge i_clk) begin
        r_val4[0] <= r_p0 + VAL_W'(r_x0);
        r_val4[1] <= r_p0 + VAL_W'(r_x1);
        r_val4[2] <= r_p1 + VAL_W'(r_x0);
        r_val4[3] <= r_p1 + VAL_W'(r_x1);
    end

    // modulo store depth: reciprocal multiply, then multiply-subtract
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            qshift[l] = r_prod5[l] >> (VAL_W + LW);
            diff[l]   = QW'(r_val6[l]) - r_qd6[l];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            r_prod5[l] <= PW'(r_val4[l]) * PW'(RECIP[MW-1:0]);
            r_val5[l]  <= r_val4[l];
            r_qd6[l]   <= QW'(qshift[l][VAL_W-1:0]) * QW'(D);
            r_val6[l]  <= r_val5[l];
        end
    end

    // texel store copies, written at the read stage to keep item order
    assign ram_we = r_vld[6] && !r_smp[6] && (32'(r_widx[6]) < 32'(D));

    for (genvar g = 0; g < 4; g++) begin : g_store
        bts_ram #(
            .WIDTH (RW),
            .DEPTH (D)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (AW'(r_widx[6])),
            .i_wdata (r_wrgb[6]),
            .i_raddr (diff[g][AW-1:0]),
            .o_rdata (rdata[g])
        );
    end

    // horizontal blend per channel, stage eight
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_top[c] <= TW'(rdata[0][RW-1-CH_W*c -: CH_W]) * TW'(WONE - (W+1)'(r_wx[7]))
                      + TW'(rdata[1][RW-1-CH_W*c -: CH_W]) * TW'(r_wx[7]);
            r_bot[c] <= TW'(rdata[2][RW-1-CH_W*c -: CH_W]) * TW'(WONE - (W+1)'(r_wx[7]))
                      + TW'(rdata[3][RW-1-CH_W*c -: CH_W]) * TW'(r_wx[7]);
        end
    end

    // vertical blend and scaling to 8.8
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            blend[c] = {VW'(r_top[c]) * VW'(WONE - (W+1)'(r_wy[8]))
                        + VW'(r_bot[c]) * VW'(r_wy[8]), 8'd0} >> (2 * W);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[8] && r_smp[8];
        end
        for (int c = 0; c < 3; c++) begin
            r_out[c] <= blend[c][OUT_W-1:0];
        end
    end

    assign o_valid     = r_ovld;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];

    // a result only follows a sample item at the last stage
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vld[8]) && $past(r_smp[8]))
        else $error("result strobe without a sample item");

    // reduced read addresses of neighbours 0 and 3 lie inside the store
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] && r_smp[6] |-> diff[0] < QW'(D) && diff[3] < QW'(D))
        else $error("texel address outside store");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && !r_vld[1])
        else $error("item in flight after reset");

endmodule
